// ===== design/ssq_pkg.sv =====
package ssq_pkg;

   // Fixed field widths
   localparam int ID_W  = 8;
   localparam int SEC_W = 32;
   localparam int SUB_W = 20;

   // Result kinds
   localparam logic [1:0] KIND_INSERTED = 2'd0;
   localparam logic [1:0] KIND_WOKEN    = 2'd1;
   localparam logic [1:0] KIND_NONE_DUE = 2'd2;
   localparam logic [1:0] KIND_DROPPED  = 2'd3;

   // Request selector
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_TICK   = 1'b1;

   // Most entries woken by one tick
   localparam int MAX_WAKE = 16;
   localparam int WAKE_W   = $clog2(MAX_WAKE + 1);

   // One queue entry (also used as the broadcast compare key)
   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [SEC_W-1:0] sec;
      logic [SUB_W-1:0] sub;
   } entry_type;

   // Per-cycle command to the cell row
   typedef struct packed {
      logic ins;
      logic pop;
   } cmd_type;

endpackage

// ===== design/ssq_cell.sv =====
module ssq_cell (
   input  logic               clock,
   input  ssq_pkg::cmd_type   cmd,
   input  ssq_pkg::entry_type key,
   input  ssq_pkg::entry_type prev_entry,
   input  ssq_pkg::entry_type next_entry,
   input  logic               prev_keep,
   input  logic               cell_valid,
   output ssq_pkg::entry_type entry,
   output logic               keep
);
   import ssq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      later;

   // Stored deadline strictly later than the key
   assign later = (entry_ff.sec > key.sec) ||
                  ((entry_ff.sec == key.sec) && (entry_ff.sub > key.sub));

   // Holds its place on insert; on a tick this means due
   assign keep  = cell_valid && !later;
   assign entry = entry_ff;

   // Insert: stay, take the new entry at the boundary, or shift right.
   // Pop: shift left.
   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins) begin
         if (!keep) begin
            entry_in = prev_keep ? key : prev_entry;
         end
      end else if (cmd.pop) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== design/sorted_sleep_timer_queue.sv =====
// Channel  Dir  Handshake          Contents
// req      in   req_tvalid/tready  tuser: func; tdata: id, deadline, now
// rsp      out  rsp_tvalid/tready  tuser: kind; tdata: woken id; tlast: last
//
// Insert: capture, then one shift of the cell row.
// Tick: capture, then one pop per woken entry, or one none-due result if
// nothing is due; the row pops one entry per cycle at its head unless a result stalls.
// Reset empties the queue at once; entry contents are not cleared.
// A stalled result holds the row; no new request is taken until the
// current one has handed off all its results to the output register.
module sorted_sleep_timer_queue #(
   parameter int QUEUE_DEPTH    = 16,
   parameter int SUBSEC_PER_SEC = 1000000
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [7:0] task_id, [39:8] deadline_seconds, [59:40] deadline_subseconds,
   // [91:60] now_seconds, [111:92] now_subseconds
   input  logic [111:0] req_tdata,
   // [0] func
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [7:0] woken_id
   output logic [7:0]   rsp_tdata,
   // [1:0] kind
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast
);
   import ssq_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [SUB_W-1:0] SUB_LIM = SUB_W'(SUBSEC_PER_SEC);
   localparam logic [SUB_W-1:0] SUB_MAX = SUB_W'(SUBSEC_PER_SEC - 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_INSERT = 2'd1;
   localparam logic [1:0] ST_WAKE   = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [WAKE_W-1:0] woken_ff, woken_in;
   entry_type         key_ff, key_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic              rsp_last_ff, rsp_last_in;

   cmd_type           cmd;
   entry_type         cells [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] keep;
   logic              out_free;
   logic              req_fire;
   logic [SUB_W-1:0]  dsub_raw, nsub_raw;
   logic              wake_last;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign dsub_raw   = req_tdata[59:40];
   assign nsub_raw   = req_tdata[111:92];

   // Cell row
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type prev_e, next_e;
      logic      prev_k;
      if (i == 0) begin : g_head
         assign prev_e = key_ff;
         assign prev_k = 1'b1;
      end else begin : g_body
         assign prev_e = cells[i-1];
         assign prev_k = keep[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign next_e = cells[i];
      end else begin : g_inner
         assign next_e = cells[i+1];
      end
      ssq_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .key        (key_ff),
         .prev_entry (prev_e),
         .next_entry (next_e),
         .prev_keep  (prev_k),
         .cell_valid (count_ff > CNT_W'(i)),
         .entry      (cells[i]),
         .keep       (keep[i])
      );
   end

   // Last wake of this tick: next entry not due or wake cap reached
   assign wake_last = !keep[1] || (woken_ff == WAKE_W'(MAX_WAKE - 1));

   // Control
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      woken_in     = woken_ff;
      key_in       = key_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_last_in  = rsp_last_ff;
      cmd          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               woken_in = '0;
               key_in.id = req_tdata[7:0];
               if (req_tuser == FUNC_TICK) begin
                  key_in.sec = req_tdata[91:60];
                  key_in.sub = (nsub_raw >= SUB_LIM) ? SUB_MAX : nsub_raw;
                  state_in   = ST_WAKE;
               end else begin
                  key_in.sec = req_tdata[39:8];
                  key_in.sub = (dsub_raw >= SUB_LIM) ? SUB_MAX : dsub_raw;
                  state_in   = ST_INSERT;
               end
            end
         end
         ST_INSERT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = key_ff.id;
               rsp_last_in  = 1'b1;
               if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                  rsp_kind_in = KIND_DROPPED;
               end else begin
                  rsp_kind_in = KIND_INSERTED;
                  cmd.ins     = 1'b1;
                  count_in    = count_ff + CNT_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         ST_WAKE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (keep[0] && (woken_ff < WAKE_W'(MAX_WAKE))) begin
                  rsp_kind_in = KIND_WOKEN;
                  rsp_id_in   = cells[0].id;
                  rsp_last_in = wake_last;
                  cmd.pop     = 1'b1;
                  count_in    = count_ff - CNT_W'(1);
                  woken_in    = woken_ff + WAKE_W'(1);
                  if (wake_last) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  rsp_kind_in = KIND_NONE_DUE;
                  rsp_id_in   = '0;
                  rsp_last_in = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         woken_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         woken_ff     <= woken_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_id_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== tb/ssq_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the sleep timer queue, keeps its own copy of the
// sorted wake-up list, and compares every result against the oldest
// expectation.
module ssq_checker #(
   parameter int QUEUE_DEPTH    = 16,
   parameter int SUBSEC_PER_SEC = 1000000
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   // [7:0] task_id, [39:8] deadline_seconds, [59:40] deadline_subseconds,
   // [91:60] now_seconds, [111:92] now_subseconds
   input  logic [111:0] req_tdata,
   // [0] func
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [7:0] woken_id
   input  logic [7:0]   rsp_tdata,
   // [1:0] kind
   input  logic [1:0]   rsp_tuser,
   input  logic         rsp_tlast,
   output int           fail_count,
   output int           pending
);
   import ssq_pkg::*;

   typedef struct {
      logic [1:0]       kind;
      logic [ID_W-1:0]  id;
      logic             last;
   } outcome_type;

   typedef struct {
      logic [ID_W-1:0]  id;
      logic [SEC_W-1:0] sec;
      logic [SUB_W-1:0] sub;
   } sleeper_type;

   // Expected results in order, and the predicted sorted wake-up list
   outcome_type outcome_q[$];
   sleeper_type sleepers[$];
   outcome_type head;

   // Out-of-range subseconds saturate to the last valid value
   function automatic logic [SUB_W-1:0] clamp_subsec(input logic [SUB_W-1:0] v);
      if (v >= SUBSEC_PER_SEC) return SUB_W'(SUBSEC_PER_SEC - 1);
      return v;
   endfunction

   // True when time a is strictly later than time b
   function automatic bit is_later(input logic [SEC_W-1:0] a_sec,
                                   input logic [SUB_W-1:0] a_sub,
                                   input logic [SEC_W-1:0] b_sec,
                                   input logic [SUB_W-1:0] b_sub);
      return (a_sec > b_sec) || (a_sec == b_sec && a_sub > b_sub);
   endfunction

   task automatic report_mismatch(input string msg);
      fail_count++;
      if (fail_count <= 100) $display("MISMATCH at %0t ns: %s", $time, msg);
   endtask

   // Apply one accepted request to the wake-up list and queue its results
   task automatic predict_request(input logic func, input logic [111:0] d);
      sleeper_type      s;
      int               pos;
      int               due;
      logic [SEC_W-1:0] now_sec;
      logic [SUB_W-1:0] now_sub;
      if (func == FUNC_INSERT) begin
         s.id  = d[7:0];
         s.sec = d[39:8];
         s.sub = clamp_subsec(d[59:40]);
         if (sleepers.size() >= QUEUE_DEPTH) begin
            outcome_q.push_back('{KIND_DROPPED, s.id, 1'b1});
         end else begin
            // goes after every entry due at or before it, so ties keep order
            pos = 0;
            while (pos < sleepers.size() &&
                   !is_later(sleepers[pos].sec, sleepers[pos].sub, s.sec, s.sub))
               pos++;
            sleepers.insert(pos, s);
            outcome_q.push_back('{KIND_INSERTED, s.id, 1'b1});
         end
      end else begin
         now_sec = d[91:60];
         now_sub = clamp_subsec(d[111:92]);
         due = 0;
         while (due < sleepers.size() && due < MAX_WAKE &&
                !is_later(sleepers[due].sec, sleepers[due].sub, now_sec, now_sub))
            due++;
         if (due == 0) begin
            outcome_q.push_back('{KIND_NONE_DUE, '0, 1'b1});
         end else begin
            for (int i = 0; i < due; i++) begin
               outcome_q.push_back('{KIND_WOKEN, sleepers[0].id, (i == due - 1)});
               void'(sleepers.pop_front());
            end
         end
      end
   endtask

   // Results are checked before the request of the same edge is predicted
   always @(posedge clock) begin
      if (reset) begin
         sleepers.delete();
         outcome_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (outcome_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result kind %0d id %0d last %0b",
                                         rsp_tuser, rsp_tdata, rsp_tlast));
            end else begin
               head = outcome_q.pop_front();
               if (rsp_tuser !== head.kind)
                  report_mismatch($sformatf("kind %0d, expected %0d",
                                            rsp_tuser, head.kind));
               if (rsp_tdata !== head.id)
                  report_mismatch($sformatf("id %0d, expected %0d (kind %0d)",
                                            rsp_tdata, head.id, head.kind));
               if (rsp_tlast !== head.last)
                  report_mismatch($sformatf("last %0b, expected %0b (id %0d)",
                                            rsp_tlast, head.last, head.id));
            end
         end
         if (req_tvalid && req_tready) predict_request(req_tuser, req_tdata);
      end
      pending = outcome_q.size();
   end

endmodule

// ===== tb/tb_sorted_sleep_timer_queue.sv =====
`timescale 1ns / 1ps

module tb_sorted_sleep_timer_queue;
   import ssq_pkg::*;

   localparam int DEPTH  = 16;
   localparam int SUBSEC = 1000000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [111:0] req_tdata;
   logic         req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [7:0]   rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   int           fail_count;
   int           pending;

   // No idling on either side once set
   bit calm;

   sorted_sleep_timer_queue #(
      .QUEUE_DEPTH   (DEPTH),
      .SUBSEC_PER_SEC(SUBSEC)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   ssq_checker #(
      .QUEUE_DEPTH   (DEPTH),
      .SUBSEC_PER_SEC(SUBSEC)
   ) wake_check (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .fail_count(fail_count),
      .pending   (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop for a hung run
   initial begin
      #4000000;
      $display("Some tests failed");
      $finish;
   end

   // Receiver: random stall bursts and ready stretches
   initial begin
      int span;
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            span = $urandom_range(1, 16);
         end else begin
            rsp_tready <= 1'b1;
            span = $urandom_range(1, 24);
         end
         repeat (span) @(posedge clock);
      end
   end

   // Hold one request until it is taken
   task automatic send_req(input logic func, input logic [111:0] data);
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
   endtask

   // Unused fields carry random junk
   task automatic send_insert(input logic [7:0] id, input logic [31:0] sec,
                              input logic [19:0] sub);
      send_req(FUNC_INSERT, {20'($urandom), 32'($urandom), sub, sec, id});
   endtask

   task automatic send_tick(input logic [31:0] sec, input logic [19:0] sub);
      send_req(FUNC_TICK, {sub, sec, 20'($urandom), 32'($urandom), 8'($urandom)});
   endtask

   task automatic sender_gap();
      int span;
      if (!calm && $urandom_range(0, 4) == 0) begin
         span = $urandom_range(1, 16);
         req_tvalid <= 1'b0;
         repeat (span) @(posedge clock);
      end
   endtask

   // Stop sending until every expected result is in, with a limit
   task automatic settle();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      do begin
         @(negedge clock);
         waited++;
      end while (pending != 0 && waited < 20000);
      @(posedge clock);
   endtask

   // Mostly legal subseconds, sometimes above range to hit saturation
   function automatic logic [19:0] rand_sub();
      if ($urandom_range(0, 7) == 0) return 20'($urandom);
      return 20'($urandom_range(0, SUBSEC - 1));
   endfunction

   initial begin
      int               ins_pct;
      int               step;
      logic [31:0]      cur_sec;
      logic [19:0]      cur_sub;
      logic [31:0]      tie_sec;
      logic [19:0]      tie_sub;
      logic [31:0]      dl_sec;
      logic [19:0]      dl_sub;

      calm = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= FUNC_INSERT;
      req_tdata  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty tick, extremes, ties, saturation, full queue, big wake
      send_tick(32'hFFFF_FFFF, 20'hFFFFF);
      send_insert(8'h00, 32'd0, 20'd0);
      send_insert(8'hFF, 32'hFFFF_FFFF, 20'hFFFFF);
      send_insert(8'h5A, 32'd0, 20'd999999);
      send_insert(8'hA5, 32'd0, 20'd0);
      send_tick(32'd0, 20'd0);
      send_tick(32'd0, 20'd999998);
      send_tick(32'd0, 20'd1000000);
      for (int k = 0; k < DEPTH - 1; k++)
         send_insert(8'h10 + 8'(k), 32'd40 - 32'(k), 20'(k * 37000));
      send_insert(8'hC3, 32'd5, 20'd0);
      send_insert(8'h3C, 32'hFFFF_FFFF, 20'hFFFFF);
      send_tick(32'hFFFF_FFFF, 20'hFFFFF);
      settle();

      // Random: inserts near the running time, ticks that move it forward
      cur_sec = $urandom;
      cur_sub = 20'($urandom_range(0, SUBSEC - 1));
      tie_sec = cur_sec;
      tie_sub = cur_sub;
      ins_pct = 50;
      for (int n = 0; n < 380; n++) begin
         if (n % 60 == 0) begin
            case ($urandom_range(0, 2))
               0: begin ins_pct = 25; end
               1: begin ins_pct = 55; end
               default: begin ins_pct = 85; end
            endcase
         end
         if (n == 190) settle();
         if (n == 320) calm = 1'b1;
         sender_gap();

         if ($urandom_range(0, 99) < 5) begin
            // raw noise on every field
            send_req(1'($urandom), 112'({$urandom, $urandom, $urandom, $urandom}));
         end else if ($urandom_range(0, 99) < ins_pct) begin
            case ($urandom_range(0, 7))
               0: begin
                  dl_sec = tie_sec;
                  dl_sub = tie_sub;
               end
               1: begin
                  dl_sec = cur_sec - 32'($urandom_range(0, 2));
                  dl_sub = rand_sub();
               end
               default: begin
                  dl_sec = cur_sec + 32'($urandom_range(0, 3));
                  dl_sub = rand_sub();
               end
            endcase
            tie_sec = dl_sec;
            tie_sub = dl_sub;
            send_insert(8'($urandom), dl_sec, dl_sub);
         end else begin
            case ($urandom_range(0, 5))
               0: begin end
               1: begin cur_sec = cur_sec + 32'($urandom_range(2, 8)); end
               default: begin
                  step = int'(cur_sub) + $urandom_range(0, 700000);
                  if (step >= SUBSEC) begin
                     step -= SUBSEC;
                     cur_sec++;
                  end
                  cur_sub = 20'(step);
               end
            endcase
            if ($urandom_range(0, 9) == 0)
               send_tick(cur_sec, 20'($urandom_range(SUBSEC, 20'hFFFFF)));
            else
               send_tick(cur_sec, cur_sub);
         end
      end

      // Drain, then give the block time to show any stray result
      settle();
      repeat (40) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
